### hdl/mer_pkg.sv
package mer_pkg;

  localparam int PIX_W = 12;
  localparam int DEC_W = 40;
  localparam int SMY_W = 10;
  localparam logic [SMY_W-1:0] SMY_RESET = 10'd479;

  // scaling applied to a product before it joins the accumulator
  typedef enum logic [1:0] {
    SH_X1,
    SH_X2,
    SH_X4
  } shift_t;

  typedef struct packed {
    logic   clr;
    logic   en;
    logic   neg;
    shift_t sh;
  } mac_op_t;

  typedef struct packed {
    logic start;
    logic done_mode;
  } emit_req_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RX2,
    ST_RY2,
    ST_Q0,
    ST_Q1,
    ST_Q2,
    ST_QW,
    ST_QR,
    ST_C0,
    ST_C1,
    ST_CW,
    ST_CD,
    ST_I0,
    ST_I1,
    ST_I2,
    ST_I3,
    ST_I4,
    ST_IW,
    ST_IR,
    ST_R0,
    ST_U0,
    ST_U1,
    ST_U2,
    ST_UW,
    ST_UA,
    ST_EMIT,
    ST_EMITD,
    ST_EWAIT
  } seq_state_t;

endpackage

### hdl/mer_mac.sv
module mer_mac #(
  parameter int MW    = 26,
  parameter int ACC_W = 60
) (
  input  logic                    clk,
  input  logic                    rst,
  input  mer_pkg::mac_op_t        op,
  input  logic [MW-1:0]           a,
  input  logic [MW-1:0]           b,
  output logic [2*MW-1:0]         prod,
  output logic signed [ACC_W-1:0] acc
);

  mer_pkg::mac_op_t        op_q;
  logic [2*MW-1:0]         prod_c;
  logic signed [ACC_W-1:0] ext;
  logic signed [ACC_W-1:0] mag;
  logic signed [ACC_W-1:0] term;

  assign prod_c = a * b;

  always_ff @(posedge clk) begin
    prod <= prod_c;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      op_q <= '0;
    end else begin
      op_q <= op;
    end
  end

  always_comb begin
    ext = ACC_W'(prod);
    case (op_q.sh)
      mer_pkg::SH_X1: mag = ext;
      mer_pkg::SH_X2: mag = ext << 1;
      mer_pkg::SH_X4: mag = ext << 2;
      default:        mag = ext;
    endcase
    term = op_q.neg ? -mag : mag;
  end

  // second stage: fold the registered product into the running sum
  always_ff @(posedge clk) begin
    if (op_q.clr) begin
      acc <= op_q.en ? term : '0;
    end else if (op_q.en) begin
      acc <= acc + term;
    end
  end

endmodule

### hdl/mer_emit.sv
module mer_emit #(
  parameter int COORD_BITS  = 10,
  parameter int RADIUS_BITS = 9
) (
  input  logic                          clk,
  input  logic                          rst,
  input  mer_pkg::emit_req_t            req,
  input  logic [mer_pkg::PIX_W-1:0]     ccol,
  input  logic [mer_pkg::PIX_W-1:0]     crow,
  input  logic [COORD_BITS-1:0]         wx,
  input  logic [RADIUS_BITS-1:0]        wy,
  output logic                          active,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [mer_pkg::PIX_W-1:0] pix_x,
  output logic signed [mer_pkg::PIX_W-1:0] pix_y,
  output logic                          pix_valid,
  output logic                          pix_done,
  output logic                          pix_last
);

  localparam int PW = mer_pkg::PIX_W;
  localparam logic [1:0] LAST_BEAT = 2'd3;

  logic [1:0]    beat;
  logic          done_mode;
  logic          load;
  logic          final_beat;
  logic [PW-1:0] dx;
  logic [PW-1:0] dy;

  assign load       = active && (!out_valid || out_ready);
  assign final_beat = done_mode || (beat == LAST_BEAT);
  assign dx         = PW'(wx);
  assign dy         = PW'(wy);

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (req.start) begin
        active <= 1'b1;
      end else if (load && final_beat) begin
        active <= 1'b0;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // beat order: (+x,+y) (-x,+y) (+x,-y) (-x,-y)
  always_ff @(posedge clk) begin
    if (req.start) begin
      beat      <= '0;
      done_mode <= req.done_mode;
    end else if (load) begin
      beat <= beat + 2'd1;
    end
    if (load) begin
      pix_x     <= done_mode ? '0 : (beat[0] ? ccol - dx : ccol + dx);
      pix_y     <= done_mode ? '0 : (beat[1] ? crow - dy : crow + dy);
      pix_valid <= !done_mode;
      pix_done  <= done_mode;
      pix_last  <= final_beat;
    end
  end

endmodule

### hdl/mer_seq.sv
module mer_seq #(
  parameter int COORD_BITS  = 10,
  parameter int RADIUS_BITS = 9,
  parameter int MW          = 26,
  parameter int ACC_W       = 60
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          func,
  input  logic [COORD_BITS-1:0]         center_x,
  input  logic [COORD_BITS-1:0]         center_y,
  input  logic [RADIUS_BITS-1:0]        radius_x,
  input  logic [RADIUS_BITS-1:0]        radius_y,
  input  logic [mer_pkg::SMY_W-1:0]     screen_max_y,
  output mer_pkg::mac_op_t              op,
  output logic [MW-1:0]                 a,
  output logic [MW-1:0]                 b,
  input  logic [2*MW-1:0]               prod,
  input  logic signed [ACC_W-1:0]       acc,
  output mer_pkg::emit_req_t            req,
  input  logic                          emit_active,
  output logic [mer_pkg::PIX_W-1:0]     ccol,
  output logic [mer_pkg::PIX_W-1:0]     crow,
  output logic [COORD_BITS-1:0]         wx,
  output logic [RADIUS_BITS-1:0]        wy
);

  localparam int PW = mer_pkg::PIX_W;
  localparam int DW = mer_pkg::DEC_W;
  localparam int R2 = 2 * RADIUS_BITS;

  mer_pkg::seq_state_t state, state_next;

  logic [RADIUS_BITS-1:0] rx;
  logic [RADIUS_BITS-1:0] ry;
  logic [R2-1:0]          rx2;
  logic [R2-1:0]          ry2;
  logic signed [DW-1:0]   dec;
  logic                   reg2;
  logic                   fin;
  logic                   xinc;
  logic                   ydec;

  logic [COORD_BITS:0]     tx;
  logic [RADIUS_BITS-1:0]  ym;
  logic                    dec_nonpos;
  logic                    q_low;
  logic signed [ACC_W-1:0] rnd;
  logic signed [DW-1:0]    dec_rnd;

  assign tx         = {wx, 1'b1};
  assign ym         = (wy == '0) ? RADIUS_BITS'(1) : wy - RADIUS_BITS'(1);
  assign dec_nonpos = dec[DW-1] || (dec == '0);

  // round quarter units half up, truncating toward zero
  assign q_low   = (acc <= $signed(ACC_W'(-3)));
  assign rnd     = acc + (q_low ? $signed(ACC_W'(5)) : $signed(ACC_W'(2)));
  assign dec_rnd = rnd[DW+1:2];

  always_comb begin
    state_next = state;
    case (state)
      mer_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (!func) begin
            state_next = mer_pkg::ST_RX2;
          end else if (fin) begin
            state_next = mer_pkg::ST_EMITD;
          end else if (reg2) begin
            state_next = mer_pkg::ST_R0;
          end else begin
            state_next = mer_pkg::ST_C0;
          end
        end
      end
      mer_pkg::ST_RX2: state_next = mer_pkg::ST_RY2;
      mer_pkg::ST_RY2: state_next = mer_pkg::ST_Q0;
      mer_pkg::ST_Q0:  state_next = mer_pkg::ST_Q1;
      mer_pkg::ST_Q1:  state_next = mer_pkg::ST_Q2;
      mer_pkg::ST_Q2:  state_next = mer_pkg::ST_QW;
      mer_pkg::ST_QW:  state_next = mer_pkg::ST_QR;
      mer_pkg::ST_QR:  state_next = mer_pkg::ST_EMIT;
      mer_pkg::ST_C0:  state_next = mer_pkg::ST_C1;
      mer_pkg::ST_C1:  state_next = mer_pkg::ST_CW;
      mer_pkg::ST_CW:  state_next = mer_pkg::ST_CD;
      mer_pkg::ST_CD: begin
        state_next = acc[ACC_W-1] ? mer_pkg::ST_U0 : mer_pkg::ST_I0;
      end
      mer_pkg::ST_I0:  state_next = mer_pkg::ST_I1;
      mer_pkg::ST_I1:  state_next = mer_pkg::ST_I2;
      mer_pkg::ST_I2:  state_next = mer_pkg::ST_I3;
      mer_pkg::ST_I3:  state_next = mer_pkg::ST_I4;
      mer_pkg::ST_I4:  state_next = mer_pkg::ST_IW;
      mer_pkg::ST_IW:  state_next = mer_pkg::ST_IR;
      mer_pkg::ST_IR:  state_next = mer_pkg::ST_R0;
      mer_pkg::ST_R0: begin
        state_next = (wy == '0) ? mer_pkg::ST_EMITD : mer_pkg::ST_U0;
      end
      mer_pkg::ST_U0:  state_next = mer_pkg::ST_U1;
      mer_pkg::ST_U1:  state_next = mer_pkg::ST_U2;
      mer_pkg::ST_U2:  state_next = mer_pkg::ST_UW;
      mer_pkg::ST_UW:  state_next = mer_pkg::ST_UA;
      mer_pkg::ST_UA:  state_next = mer_pkg::ST_EMIT;
      mer_pkg::ST_EMIT:  state_next = mer_pkg::ST_EWAIT;
      mer_pkg::ST_EMITD: state_next = mer_pkg::ST_EWAIT;
      mer_pkg::ST_EWAIT: begin
        if (!emit_active) begin
          state_next = mer_pkg::ST_IDLE;
        end
      end
      default: state_next = mer_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    op       = '0;
    a        = '0;
    b        = '0;
    req      = '0;
    case (state)
      mer_pkg::ST_IDLE: in_ready = 1'b1;
      mer_pkg::ST_RX2: begin
        a = MW'(rx);
        b = MW'(rx);
      end
      mer_pkg::ST_RY2: begin
        a = MW'(ry);
        b = MW'(ry);
      end
      mer_pkg::ST_Q0: begin
        a  = MW'(rx2);
        b  = MW'(ry);
        op = '{clr: 1'b1, en: 1'b1, neg: 1'b1, sh: mer_pkg::SH_X4};
      end
      mer_pkg::ST_Q1: begin
        a  = MW'(ry2);
        b  = MW'(1);
        op = '{clr: 1'b0, en: 1'b1, neg: 1'b0, sh: mer_pkg::SH_X4};
      end
      mer_pkg::ST_Q2: begin
        a  = MW'(rx2);
        b  = MW'(1);
        op = '{clr: 1'b0, en: 1'b1, neg: 1'b0, sh: mer_pkg::SH_X1};
      end
      mer_pkg::ST_C0: begin
        a  = MW'(ry2);
        b  = MW'(wx);
        op = '{clr: 1'b1, en: 1'b1, neg: 1'b0, sh: mer_pkg::SH_X1};
      end
      mer_pkg::ST_C1: begin
        a  = MW'(rx2);
        b  = MW'(wy);
        op = '{clr: 1'b0, en: 1'b1, neg: 1'b1, sh: mer_pkg::SH_X1};
      end
      mer_pkg::ST_I0: begin
        a = MW'(tx);
        b = MW'(tx);
      end
      mer_pkg::ST_I1: begin
        a  = MW'(ry2);
        b  = prod[MW-1:0];
        op = '{clr: 1'b1, en: 1'b1, neg: 1'b0, sh: mer_pkg::SH_X1};
      end
      mer_pkg::ST_I2: begin
        a = MW'(ym);
        b = MW'(ym);
      end
      mer_pkg::ST_I3: begin
        a  = MW'(rx2);
        b  = prod[MW-1:0];
        op = '{clr: 1'b0, en: 1'b1, neg: 1'b0, sh: mer_pkg::SH_X4};
      end
      mer_pkg::ST_I4: begin
        a  = MW'(rx2);
        b  = MW'(ry2);
        op = '{clr: 1'b0, en: 1'b1, neg: 1'b1, sh: mer_pkg::SH_X4};
      end
      mer_pkg::ST_U0: begin
        a  = MW'(ry2);
        b  = MW'(wx);
        op = '{clr: 1'b1, en: xinc, neg: 1'b0, sh: mer_pkg::SH_X2};
      end
      mer_pkg::ST_U1: begin
        a  = reg2 ? MW'(rx2) : MW'(ry2);
        b  = MW'(1);
        op = '{clr: 1'b0, en: 1'b1, neg: 1'b0, sh: mer_pkg::SH_X1};
      end
      mer_pkg::ST_U2: begin
        a  = MW'(rx2);
        b  = MW'(wy);
        op = '{clr: 1'b0, en: ydec, neg: 1'b1, sh: mer_pkg::SH_X2};
      end
      mer_pkg::ST_EMIT:  req = '{start: 1'b1, done_mode: 1'b0};
      mer_pkg::ST_EMITD: req = '{start: 1'b1, done_mode: 1'b1};
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mer_pkg::ST_IDLE;
      fin   <= 1'b1;
      reg2  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == mer_pkg::ST_IDLE && in_valid && !func) begin
        fin  <= 1'b0;
        reg2 <= 1'b0;
      end
      if (state == mer_pkg::ST_IR) begin
        reg2 <= 1'b1;
      end
      if (state == mer_pkg::ST_R0 && wy == '0) begin
        fin <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      mer_pkg::ST_IDLE: begin
        if (in_valid && !func) begin
          ccol <= PW'(center_x);
          crow <= PW'(screen_max_y) - PW'(center_y);
          rx   <= radius_x;
          ry   <= radius_y;
          wx   <= '0;
          wy   <= radius_y;
        end
      end
      mer_pkg::ST_RY2: rx2 <= prod[R2-1:0];
      mer_pkg::ST_Q0:  ry2 <= prod[R2-1:0];
      mer_pkg::ST_QR:  dec <= dec_rnd;
      mer_pkg::ST_IR:  dec <= dec_rnd;
      mer_pkg::ST_CD: begin
        // still in the first region: step x, and y when the decision is not negative
        if (acc[ACC_W-1]) begin
          wx   <= wx + COORD_BITS'(1);
          xinc <= 1'b1;
          ydec <= !dec[DW-1];
          if (!dec[DW-1]) begin
            wy <= wy - RADIUS_BITS'(1);
          end
        end
      end
      mer_pkg::ST_R0: begin
        if (wy != '0) begin
          wy   <= wy - RADIUS_BITS'(1);
          ydec <= 1'b1;
          xinc <= dec_nonpos;
          if (dec_nonpos) begin
            wx <= wx + COORD_BITS'(1);
          end
        end
      end
      mer_pkg::ST_UA: dec <= dec + $signed(acc[DW-1:0]);
      default: ;
    endcase
  end

endmodule

### hdl/midpoint_ellipse_rasterizer_unit.sv
// Midpoint ellipse rasterizer. A word with s_tuser = 0 starts a new ellipse from
// the centre and radii in s_tdata (the centre row is flipped as screen_max_y minus
// centre_y) and returns the four mirrored pixels of (0, ry); a word with s_tuser = 1
// advances the walk one iteration and returns four pixels, or a single done word
// (m_tuser[1] set, m_tuser[0] clear) once the quadrant is finished or before any
// start. m_tlast marks the final word of each input word. All products go through
// one shared multiplier with a two-stage multiply-accumulate, one product per
// cycle, and the four pixels leave through a one-word output register. The block
// takes no input word while it is working: it accepts the next input word only
// once the last output word of the current one is in the output register.
// screen_max_y is written through the cfg port, which is always ready.
module midpoint_ellipse_rasterizer_unit #(
  parameter int COORD_BITS  = 10,
  parameter int RADIUS_BITS = 9,
  localparam int IN_W = ((2 * COORD_BITS + 2 * RADIUS_BITS + 7) / 8) * 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // center_x, center_y, radius_x, radius_y, zero pad
  input  logic [IN_W-1:0]                   s_tdata,
  // func
  input  logic                              s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // pixel_x, pixel_y
  output logic [2*mer_pkg::PIX_W-1:0]       m_tdata,
  // pixel_valid, done_res
  output logic [1:0]                        m_tuser,
  output logic                              m_tlast,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mer_pkg::SMY_W-1:0]         cfg_data
);

  localparam int MW    = (2 * COORD_BITS + 2 > 2 * RADIUS_BITS) ?
                         2 * COORD_BITS + 2 : 2 * RADIUS_BITS;
  localparam int ACC_W = 2 * MW + 8;
  localparam int PW    = mer_pkg::PIX_W;

  logic [mer_pkg::SMY_W-1:0] screen_max_y;

  logic [COORD_BITS-1:0]  center_x;
  logic [COORD_BITS-1:0]  center_y;
  logic [RADIUS_BITS-1:0] radius_x;
  logic [RADIUS_BITS-1:0] radius_y;

  mer_pkg::mac_op_t        op;
  logic [MW-1:0]           mac_a;
  logic [MW-1:0]           mac_b;
  logic [2*MW-1:0]         prod;
  logic signed [ACC_W-1:0] acc;

  mer_pkg::emit_req_t     req;
  logic                   emit_active;
  logic [PW-1:0]          ccol;
  logic [PW-1:0]          crow;
  logic [COORD_BITS-1:0]  wx;
  logic [RADIUS_BITS-1:0] wy;

  logic signed [PW-1:0] pix_x;
  logic signed [PW-1:0] pix_y;
  logic                 pix_valid;
  logic                 pix_done;

  assign center_x = s_tdata[COORD_BITS-1:0];
  assign center_y = s_tdata[2*COORD_BITS-1:COORD_BITS];
  assign radius_x = s_tdata[2*COORD_BITS+RADIUS_BITS-1:2*COORD_BITS];
  assign radius_y = s_tdata[2*COORD_BITS+2*RADIUS_BITS-1:2*COORD_BITS+RADIUS_BITS];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_max_y <= mer_pkg::SMY_RESET;
    end else if (cfg_valid && cfg_ready) begin
      screen_max_y <= cfg_data;
    end
  end

  mer_seq #(
    .COORD_BITS  (COORD_BITS),
    .RADIUS_BITS (RADIUS_BITS),
    .MW          (MW),
    .ACC_W       (ACC_W)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .func         (s_tuser),
    .center_x     (center_x),
    .center_y     (center_y),
    .radius_x     (radius_x),
    .radius_y     (radius_y),
    .screen_max_y (screen_max_y),
    .op           (op),
    .a            (mac_a),
    .b            (mac_b),
    .prod         (prod),
    .acc          (acc),
    .req          (req),
    .emit_active  (emit_active),
    .ccol         (ccol),
    .crow         (crow),
    .wx           (wx),
    .wy           (wy)
  );

  mer_mac #(
    .MW    (MW),
    .ACC_W (ACC_W)
  ) u_mac (
    .clk  (clk),
    .rst  (rst),
    .op   (op),
    .a    (mac_a),
    .b    (mac_b),
    .prod (prod),
    .acc  (acc)
  );

  mer_emit #(
    .COORD_BITS  (COORD_BITS),
    .RADIUS_BITS (RADIUS_BITS)
  ) u_emit (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .ccol      (ccol),
    .crow      (crow),
    .wx        (wx),
    .wy        (wy),
    .active    (emit_active),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .pix_x     (pix_x),
    .pix_y     (pix_y),
    .pix_valid (pix_valid),
    .pix_done  (pix_done),
    .pix_last  (m_tlast)
  );

  assign m_tdata = {pix_y, pix_x};
  assign m_tuser = {pix_done, pix_valid};

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted twice in a row");

  a_idle_no_emit: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !emit_active)
    else $error("pixel emitter active while sequencer idle");

  a_done_word: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[1]) |-> (m_tlast && !m_tuser[0]))
    else $error("done word not marked last or flagged as pixel");
`endif

endmodule

### tb/sv/tb_midpoint_ellipse_rasterizer_unit.sv
`timescale 1ns / 100ps

module tb_midpoint_ellipse_rasterizer_unit;

  localparam int     IN_W         = 40;
  localparam int     PIX_W        = mer_pkg::PIX_W;
  localparam int     SMY_W        = mer_pkg::SMY_W;
  localparam int     DEC_W        = mer_pkg::DEC_W;
  localparam longint COORD_MASK   = 1023;
  localparam int     CYCLE_LIMIT  = 500000;
  localparam int     DRAIN_CYCLES = 40;
  localparam int     PHASE_WORDS  = 32;

  typedef enum logic {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } op_t;

  typedef struct packed {
    logic [PIX_W-1:0] px;
    logic [PIX_W-1:0] py;
    logic             valid;
    logic             done;
    logic             last;
  } pixel_word_t;

  logic              clk;
  logic              rst;
  logic              s_tvalid;
  logic              s_tready;
  logic [IN_W-1:0]   s_tdata;
  logic              s_tuser;
  logic              m_tvalid;
  logic              m_tready;
  logic [2*PIX_W-1:0] m_tdata;
  logic [1:0]        m_tuser;
  logic              m_tlast;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [SMY_W-1:0]  cfg_data;

  midpoint_ellipse_rasterizer_unit dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // predicted walk state
  longint top_row;
  longint org_x, org_y;
  longint semi_x, semi_y;
  longint cur_x, cur_y;
  longint err_term;
  bit     lower_arc;
  bit     walk_done;

  pixel_word_t pixel_queue[$];
  int          bad_words;
  int          words_sent;
  int          cycles;
  bit          steady;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic note_mismatch(string what, longint got, longint want);
    if (bad_words < 40)
      $display("mismatch on %s: got %0d, expected %0d", what, got, want);
    bad_words++;
  endtask

  function automatic longint wrap40(longint v);
    logic signed [DEC_W-1:0] t;
    t = v[DEC_W-1:0];
    return longint'(t);
  endfunction

  // round a quarter-unit value half up, truncating toward zero
  function automatic longint round_quarter(longint q);
    return (q + 2) / 4;
  endfunction

  function automatic void queue_quad();
    pixel_word_t w;
    longint      vx, vy;
    for (int k = 0; k < 4; k++) begin
      vx = k[0] ? org_x - cur_x : org_x + cur_x;
      vy = k[1] ? org_y - cur_y : org_y + cur_y;
      w.px    = vx[PIX_W-1:0];
      w.py    = vy[PIX_W-1:0];
      w.valid = 1'b1;
      w.done  = 1'b0;
      w.last  = (k == 3);
      pixel_queue.push_back(w);
    end
  endfunction

  function automatic void queue_done();
    pixel_word_t w;
    w = '0;
    w.done = 1'b1;
    w.last = 1'b1;
    pixel_queue.push_back(w);
  endfunction

  function automatic void reset_walk();
    top_row   = longint'(mer_pkg::SMY_RESET);
    org_x     = 0;
    org_y     = 0;
    semi_x    = 0;
    semi_y    = 0;
    cur_x     = 0;
    cur_y     = 0;
    err_term  = 0;
    lower_arc = 1'b0;
    walk_done = 1'b1;
  endfunction

  function automatic void predict_start(logic [9:0] cx, logic [9:0] cy,
                                        logic [8:0] rx, logic [8:0] ry);
    org_x     = longint'(cx);
    org_y     = top_row - longint'(cy);
    semi_x    = longint'(rx);
    semi_y    = longint'(ry);
    cur_x     = 0;
    cur_y     = semi_y;
    err_term  = wrap40(round_quarter(4 * semi_y * semi_y
                - 4 * semi_x * semi_x * semi_y + semi_x * semi_x));
    lower_arc = 1'b0;
    walk_done = 1'b0;
    queue_quad();
  endfunction

  function automatic void predict_step();
    longint rx2, ry2, tx, ym;
    if (walk_done) begin
      queue_done();
      return;
    end
    rx2 = semi_x * semi_x;
    ry2 = semi_y * semi_y;
    if (!lower_arc) begin
      if (ry2 * cur_x < rx2 * cur_y) begin
        cur_x = (cur_x + 1) & COORD_MASK;
        if (err_term >= 0) begin
          cur_y = cur_y - 1;
          err_term = wrap40(err_term + 2 * ry2 * cur_x + ry2 - 2 * rx2 * cur_y);
        end else begin
          err_term = wrap40(err_term + 2 * ry2 * cur_x + ry2);
        end
        queue_quad();
        return;
      end
      // switch to the steep part and fall through to its first iteration
      tx = 2 * cur_x + 1;
      ym = cur_y - 1;
      err_term  = wrap40(round_quarter(ry2 * tx * tx + 4 * rx2 * ym * ym - 4 * rx2 * ry2));
      lower_arc = 1'b1;
    end
    if (cur_y == 0) begin
      walk_done = 1'b1;
      queue_done();
      return;
    end
    cur_y = cur_y - 1;
    if (err_term <= 0) begin
      cur_x = (cur_x + 1) & COORD_MASK;
      err_term = wrap40(err_term - 2 * rx2 * cur_y + rx2 + 2 * ry2 * cur_x);
    end else begin
      err_term = wrap40(err_term - 2 * rx2 * cur_y + rx2);
    end
    queue_quad();
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [9:0] rand10(int lo, int hi);
    int t;
    t = $urandom_range(lo, hi);
    return t[9:0];
  endfunction

  function automatic logic [8:0] rand9(int lo, int hi);
    int t;
    t = $urandom_range(lo, hi);
    return t[8:0];
  endfunction

  task automatic send_word(op_t op, logic [9:0] cx, logic [9:0] cy,
                           logic [8:0] rx, logic [8:0] ry);
    int gap;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {2'b00, ry, rx, cy, cx};
    do @(posedge clk); while (!s_tready);
    if (op == OP_START) predict_start(cx, cy, rx, ry);
    else predict_step();
    words_sent++;
  endtask

  // a step word carries junk in the unused fields
  task automatic send_step();
    send_word(OP_STEP, rand10(0, 1023), rand10(0, 1023), rand9(0, 511), rand9(0, 511));
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    wait (pixel_queue.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_screen_max_y(logic [SMY_W-1:0] v);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    top_row = longint'(v);
  endtask

  task automatic test_directed_shapes();
    // step with nothing started
    send_step();
    // zero radii: leave the flat part at once, then finish
    send_word(OP_START, 10'd0, 10'd0, 9'd0, 9'd0);
    send_step();
    send_step();
    // largest centre and radii, row flips below zero
    send_word(OP_START, 10'd1023, 10'd1023, 9'd511, 9'd511);
    send_step();
    send_step();
    // zero x radius walks the steep part only, then runs past the end
    send_word(OP_START, 10'd512, 10'd240, 9'd0, 9'd3);
    repeat (5) send_step();
    // zero y radius finishes on the first step
    send_word(OP_START, 10'd100, 10'd100, 9'd6, 9'd0);
    send_step();
    // very flat, then restart mid-walk with a very tall one
    send_word(OP_START, 10'd700, 10'd300, 9'd511, 9'd1);
    send_step();
    send_word(OP_START, 10'd341, 10'd682, 9'd1, 9'd511);
    send_step();
  endtask

  task automatic test_row_flip();
    write_screen_max_y(10'd1023);
    send_word(OP_START, 10'd0, 10'd0, 9'd2, 9'd1);
    send_step();
    write_screen_max_y(10'd0);
    send_word(OP_START, 10'd1023, 10'd1023, 9'd0, 9'd2);
    send_step();
  endtask

  task automatic random_walk();
    logic [8:0] rx, ry;
    int         r, cap, n;
    r = $urandom_range(0, 99);
    if (r < 72) begin
      rx  = rand9(0, 12);
      ry  = rand9(0, 12);
      cap = 200;
    end else if (r < 88) begin
      rx  = rand9(13, 60);
      ry  = rand9(13, 60);
      cap = $urandom_range(4, 20);
    end else begin
      // full-range radii, cut short to keep the run bounded
      rx  = rand9(0, 511);
      ry  = rand9(0, 511);
      cap = $urandom_range(1, 6);
    end
    if ($urandom_range(0, 7) == 0) cap = $urandom_range(0, 5);
    send_word(OP_START, rand10(0, 1023), rand10(0, 1023), rx, ry);
    n = 0;
    while (!walk_done && n < cap) begin
      send_step();
      n++;
    end
    if (walk_done) repeat ($urandom_range(0, 2)) send_step();
  endtask

  task automatic random_noise();
    repeat ($urandom_range(1, 3)) begin
      if ($urandom_range(0, 1) == 0) send_step();
      else send_word(OP_START, rand10(0, 1023), rand10(0, 1023), rand9(0, 511), rand9(0, 511));
    end
  endtask

  task automatic test_random_walks();
    logic [SMY_W-1:0] row_pick;
    int               target;
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0:       row_pick = 10'd1023;
        1:       row_pick = 10'd0;
        default: row_pick = rand10(0, 1023);
      endcase
      write_screen_max_y(row_pick);
      target = words_sent + PHASE_WORDS;
      while (words_sent < target) begin
        steady = ($urandom_range(0, 6) == 0);
        if ($urandom_range(0, 9) == 0) random_noise();
        else random_walk();
      end
      steady = 1'b0;
    end
  endtask

  initial begin : out_stall
    int busy, hold, r;
    m_tready <= 1'b0;
    @(posedge clk);
    forever begin
      r = $urandom_range(0, 99);
      busy = (r < 85) ? $urandom_range(1, 8) : $urandom_range(40, 150);
      m_tready <= 1'b1;
      repeat (busy) @(posedge clk);
      r = $urandom_range(0, 99);
      hold = (r < 35) ? 0 : (r < 88) ? $urandom_range(1, 3) : $urandom_range(10, 50);
      if (hold > 0) begin
        m_tready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    pixel_word_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pixel_queue.size() == 0) begin
        note_mismatch("word with none expected", longint'(m_tdata), 0);
      end else begin
        want = pixel_queue.pop_front();
        if (m_tdata[PIX_W-1:0] !== want.px)
          note_mismatch("pixel_x", longint'(m_tdata[PIX_W-1:0]), longint'(want.px));
        if (m_tdata[2*PIX_W-1:PIX_W] !== want.py)
          note_mismatch("pixel_y", longint'(m_tdata[2*PIX_W-1:PIX_W]), longint'(want.py));
        if (m_tuser[0] !== want.valid)
          note_mismatch("pixel_valid", longint'(m_tuser[0]), longint'(want.valid));
        if (m_tuser[1] !== want.done)
          note_mismatch("done_res", longint'(m_tuser[1]), longint'(want.done));
        if (m_tlast !== want.last)
          note_mismatch("last", longint'(m_tlast), longint'(want.last));
      end
    end
  end

  initial begin
    words_sent = 0;
    steady     = 1'b0;
    reset_walk();
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_directed_shapes();
    test_row_flip();
    test_random_walks();
    s_tvalid <= 1'b0;
    wait (pixel_queue.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (bad_words == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
